[design/iwt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwt_pkg: shared types and constants for the integer-to-word-tokens block
// Token codes, digit-conversion sizes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package iwt_pkg;

	localparam int VALUE_W    = 31;
	localparam int CODE_W     = 5;
	localparam int DIGITS     = 10;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int CONV_STEPS = VALUE_W;
	localparam int STEP_W     = 5;
	localparam int MAX_TOKENS = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 5;
	localparam int GRP_W      = 2;
	localparam int SUB_W      = 3;

	// Word token codes
	localparam logic [CODE_W-1:0] TOK_ZERO      = 5'd0;
	localparam logic [CODE_W-1:0] TOK_TEN       = 5'd10;
	localparam logic [CODE_W-1:0] TOK_TENS_BASE = 5'd18;
	localparam logic [CODE_W-1:0] TOK_HUNDRED   = 5'd28;

	// Steps within one three-digit group
	localparam logic [SUB_W-1:0] SUB_HUND_DIGIT = 3'd0;
	localparam logic [SUB_W-1:0] SUB_HUND_WORD  = 3'd1;
	localparam logic [SUB_W-1:0] SUB_TENS       = 3'd2;
	localparam logic [SUB_W-1:0] SUB_UNITS      = 3'd3;
	localparam logic [SUB_W-1:0] SUB_SCALE      = 3'd4;

	localparam logic [GRP_W-1:0] GRP_TOP = 2'd3;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic build_step;
		logic load_out;
	} iwt_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic conv_last;
		logic build_last;
		logic out_last;
	} iwt_sts_t;

endpackage

[design/integer_to_word_tokens.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_word_tokens: reads a 31-bit integer out as English word tokens
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance the value is converted
// to ten BCD digits (one shift-and-add-3 step per bit), then a build pass
// walks the four three-digit groups and five steps per group, writing each
// word into a 16-entry token list. The load state puts the first token into
// the output register and tokens then leave one per cycle while the consumer
// is ready. A request producing 1 to 16 tokens occupies the block from
// acceptance to its last token, output stalls included; the next request is
// taken in the cycle after the final token.
module integer_to_word_tokens (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [iwt_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [iwt_pkg::CODE_W-1:0]   word_code,
	output logic                         last_word
);
	import iwt_pkg::*;

	iwt_cmd_t cmd;
	iwt_sts_t sts;

	iwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	iwt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.sts       (sts),
		.word_code (word_code),
		.last_word (last_word)
	);

endmodule

[design/iwt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwt_dp: datapath of the integer-to-word-tokens block
// Shift-and-add-3 binary to BCD conversion, token list build, output register.
// ----------------------------------------------------------------------------
module iwt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iwt_pkg::iwt_cmd_t             cmd,
	input  logic [iwt_pkg::VALUE_W-1:0]   value,
	output iwt_pkg::iwt_sts_t             sts,
	output logic [iwt_pkg::CODE_W-1:0]    word_code,
	output logic                          last_word
);
	import iwt_pkg::*;

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   bcd_adj;
	logic [STEP_W-1:0]  step_q;

	logic [GRP_W-1:0]   grp_q;
	logic [SUB_W-1:0]   sub_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   rd_q;
	logic [CODE_W-1:0]  tok_mem [MAX_TOKENS];

	logic [CODE_W-1:0]  word_q;
	logic               last_q;

	logic [47:0]        bcd_ext;
	logic [5:0]         gbase;
	logic [3:0]         dig_h;
	logic [3:0]         dig_t;
	logic [3:0]         dig_o;
	logic               grp_nz;
	logic               tok_present;
	logic [CODE_W-1:0]  tok_code;
	logic               build_last;
	logic               zero_fill;

	// Add three to every BCD digit of five or more
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Pick the three digits of the current group
	assign bcd_ext = {8'd0, bcd_q};
	assign gbase   = {1'b0, grp_q, 3'b000} + {2'b00, grp_q, 2'b00};
	assign dig_o   = bcd_ext[gbase +: 4];
	assign dig_t   = bcd_ext[(gbase + 6'd4) +: 4];
	assign dig_h   = bcd_ext[(gbase + 6'd8) +: 4];
	assign grp_nz  = (dig_h != 4'd0) || (dig_t != 4'd0) || (dig_o != 4'd0);

	// Decide whether the current step yields a token, and which
	always_comb begin
		tok_present = 1'b0;
		tok_code    = TOK_ZERO;
		case (sub_q)
			SUB_HUND_DIGIT: begin
				tok_present = (dig_h != 4'd0);
				tok_code    = {1'b0, dig_h};
			end
			SUB_HUND_WORD: begin
				tok_present = (dig_h != 4'd0);
				tok_code    = TOK_HUNDRED;
			end
			SUB_TENS: begin
				if (dig_t == 4'd1) begin
					tok_present = 1'b1;
					tok_code    = TOK_TEN + {1'b0, dig_o};
				end else begin
					tok_present = (dig_t >= 4'd2);
					tok_code    = TOK_TENS_BASE + {1'b0, dig_t};
				end
			end
			SUB_UNITS: begin
				tok_present = (dig_t != 4'd1) && (dig_o != 4'd0);
				tok_code    = {1'b0, dig_o};
			end
			SUB_SCALE: begin
				tok_present = grp_nz && (grp_q != '0);
				tok_code    = TOK_HUNDRED + {{(CODE_W-GRP_W){1'b0}}, grp_q};
			end
			default: begin
				tok_present = 1'b0;
				tok_code    = TOK_ZERO;
			end
		endcase
	end

	assign build_last = (grp_q == '0) && (sub_q == SUB_SCALE);
	assign zero_fill  = build_last && (cnt_q == '0);

	// Conversion and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			grp_q  <= '0;
			sub_q  <= '0;
			cnt_q  <= '0;
			rd_q   <= '0;
		end else begin
			if (cmd.load) begin
				step_q <= '0;
				grp_q  <= GRP_TOP;
				sub_q  <= SUB_HUND_DIGIT;
				cnt_q  <= '0;
				rd_q   <= '0;
			end
			if (cmd.conv_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.build_step) begin
				if (tok_present || zero_fill) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (sub_q == SUB_SCALE) begin
					sub_q <= SUB_HUND_DIGIT;
					grp_q <= grp_q - 1'b1;
				end else begin
					sub_q <= sub_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	// Shift the binary value into the BCD register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
		end
	end

	// Token list: write while building, read into the output register
	always_ff @(posedge clk) begin
		if (cmd.build_step && (tok_present || zero_fill)) begin
			tok_mem[cnt_q[IDX_W-1:0]] <= zero_fill ? TOK_ZERO : tok_code;
		end
		if (cmd.load_out) begin
			word_q <= tok_mem[rd_q];
			last_q <= (({1'b0, rd_q} + 1'b1) == cnt_q);
		end
	end

	assign sts.conv_last  = (step_q == STEP_W'(CONV_STEPS - 1));
	assign sts.build_last = build_last;
	assign sts.out_last   = last_q;
	assign word_code      = word_q;
	assign last_word      = last_q;

	// The list never overflows, is never read past its end and is never left empty
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.build_step |-> (cnt_q < CNT_W'(MAX_TOKENS)) || !(tok_present || zero_fill))
		else $error("token list overflow");

	a_rd_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> ({1'b0, rd_q} < cnt_q))
		else $error("token read beyond list end");

	a_list_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.build_step && build_last) |=> (cnt_q != '0))
		else $error("build finished with no tokens");

endmodule

[design/iwt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwt_ctrl: controller of the integer-to-word-tokens block
// Sequences load, conversion, token build and emission of each request.
// ----------------------------------------------------------------------------
module iwt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  iwt_pkg::iwt_sts_t    sts,
	output iwt_pkg::iwt_cmd_t    cmd
);
	import iwt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CONV  = 5'b00010,
		S_BUILD = 5'b00100,
		S_LOAD  = 5'b01000,
		S_EMIT  = 5'b10000
	} iwt_state_t;

	iwt_state_t state_q;
	iwt_state_t state_d;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_last) begin
					state_d = S_BUILD;
				end
			end
			S_BUILD: begin
				cmd.build_step = 1'b1;
				if (sts.build_last) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_out = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.out_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.load_out = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A new request is never taken while tokens are still shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted during emission");

	// A load is always followed by a conversion step
	a_conv_before_build: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load) |=> cmd.conv_step)
		else $error("conversion did not follow load");

	// Exactly one state is active
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

endmodule
